FILE: hw/rtl/k_inversion_permutation_count_unit_assert.svh
// ----------------------------------------------------------------------------
// k_inversion_permutation_count_unit_assert.svh
// Assertion macros shared by the inversion count unit modules
// ----------------------------------------------------------------------------
`ifndef K_INVERSION_PERMUTATION_COUNT_UNIT_ASSERT_SVH
`define K_INVERSION_PERMUTATION_COUNT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define KIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define KIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/kip_pkg.sv
// ----------------------------------------------------------------------------
// kip_pkg
// Shared widths, the prime modulus and controller/datapath bundles
// ----------------------------------------------------------------------------
package kip_pkg;

  // payload widths
  localparam int IN_W  = 11;
  localparam int OUT_W = 30;

  // default table bounds
  localparam int MAX_N_DEF = 1024;
  localparam int MAX_K_DEF = 1024;

  // modulus
  localparam logic [OUT_W-1:0] PRIME = 30'd1000000007;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch saturated n and k, clear counters
    logic init_step;  // write one entry of row zero
    logic row_step;   // issue reads for one column of the current row
    logic next_row;   // advance the row counter
    logic rd_issue;   // read the final entry
    logic capture;    // load the output register
  } kip_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic col_last;   // column counter at k
    logic row_last;   // row counter at n
    logic n_zero;     // n is zero
  } kip_stat_t;

endpackage

FILE: hw/rtl/kip_if.sv
// ----------------------------------------------------------------------------
// kip_if
// Valid/ready channels for the (n, k) request and the count result
// ----------------------------------------------------------------------------

// request channel
interface kip_in_if import kip_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] elem_count;
  logic [IN_W-1:0] inversions;

  modport source (output valid, output elem_count, output inversions, input ready);
  modport sink   (input valid, input elem_count, input inversions, output ready);
endinterface

// result channel
interface kip_out_if import kip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] perm_count;

  modport source (output valid, output perm_count, input ready);
  modport sink   (input valid, input perm_count, output ready);
endinterface

FILE: hw/rtl/kip_ctrl.sv
// ----------------------------------------------------------------------------
// kip_ctrl
// Sequencer: row zero fill, row sweeps, final read and result hand-off
// ----------------------------------------------------------------------------
`include "k_inversion_permutation_count_unit_assert.svh"

module kip_ctrl import kip_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output kip_cmd_t  cmd_o,
  input  kip_stat_t stat_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_GAP  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.col_last) begin
          state_d = stat_i.n_zero ? S_RD : S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_step = 1'b1;
        if (stat_i.col_last) begin
          state_d = S_GAP;
        end
      end
      // gap state so the last column write can land
      S_GAP: begin
        if (stat_i.row_last) begin
          state_d = S_RD;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d        = S_ROW;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RDW;
      end
      // keep reading entry k while the output register is busy
      S_RDW: begin
        cmd_o.rd_issue = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `KIP_ASSERT_NEXT(a_accept_starts_init, in_valid_i && in_ready_o, state_q == S_INIT,
                   "accepted beat did not start the row zero fill")
  `KIP_ASSERT_NOW(a_valid_from_capture, $rose(out_valid_q), $past(state_q) == S_RDW,
                  "result valid rose outside the capture step")
  `KIP_ASSERT_NEXT(a_last_row_reads, state_q == S_GAP && stat_i.row_last, state_q == S_RD,
                   "last row did not proceed to the final read")

endmodule

FILE: hw/rtl/kip_dpath.sv
// ----------------------------------------------------------------------------
// kip_dpath
// Row stores, counters and windowed modular running sum
// ----------------------------------------------------------------------------
`include "k_inversion_permutation_count_unit_assert.svh"

module kip_dpath import kip_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF,
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kip_cmd_t         cmd_i,
  output kip_stat_t        stat_o,
  input  logic [IN_W-1:0]  elem_count_i,
  input  logic [IN_W-1:0]  inversions_i,
  output logic [OUT_W-1:0] perm_count_o
);

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int KW    = $clog2(MAX_K + 1);
  localparam int DEPTH = MAX_K + 1;
  localparam int SW    = OUT_W + 2;
  localparam logic signed [SW-1:0] PRIME_S = $signed({2'b00, PRIME});

  logic [NW-1:0] n_q, i_q, n_sat;
  logic [KW-1:0] k_q, j_q, k_sat;
  logic          j_last;

  logic          stg_vld_q, stg_first_q, stg_sub_q, stg_bank_q;
  logic [KW-1:0] stg_addr_q;

  logic [KW-1:0] addr_a, addr_b;
  logic          sub_en;

  logic [OUT_W-1:0] mem0_q [DEPTH];
  logic [OUT_W-1:0] mem1_q [DEPTH];
  logic [OUT_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic             wr_en, wr_bank;
  logic [KW-1:0]    wr_addr;
  logic [OUT_W-1:0] wr_data;

  logic [OUT_W-1:0] prev_a, prev_b, base, ws_new, ws_q, perm_q;
  logic signed [SW-1:0] t_sum;

  // saturate the request to the table bounds
  assign n_sat = (32'(elem_count_i) > 32'(MAX_N)) ? NW'(MAX_N) : NW'(elem_count_i);
  assign k_sat = (32'(inversions_i) > 32'(MAX_K)) ? KW'(MAX_K) : KW'(inversions_i);

  assign j_last = (j_q == k_q);

  // row and column counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.load) begin
      n_q <= n_sat;
      k_q <= k_sat;
      i_q <= '0;
      j_q <= '0;
    end else begin
      if (cmd_i.init_step || cmd_i.row_step) begin
        j_q <= j_last ? '0 : j_q + 1'b1;
      end
      if (cmd_i.init_step && j_last) begin
        i_q <= NW'(1);
      end else if (cmd_i.next_row) begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  // read addresses: current column and the column leaving the window
  assign sub_en = (32'(j_q) >= 32'(i_q));
  assign addr_a = cmd_i.rd_issue ? k_q : j_q;
  assign addr_b = KW'(32'(j_q) - 32'(i_q));

  // stage between read issue and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= cmd_i.row_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_step) begin
      stg_first_q <= (j_q == '0);
      stg_sub_q   <= sub_en;
      stg_addr_q  <= j_q;
      stg_bank_q  <= i_q[0];
    end
  end

  // write port: row zero fill or running sum write back
  always_comb begin
    wr_en   = cmd_i.init_step | stg_vld_q;
    wr_bank = cmd_i.init_step ? 1'b0 : stg_bank_q;
    wr_addr = cmd_i.init_step ? j_q : stg_addr_q;
    if (cmd_i.init_step) begin
      wr_data = (j_q == '0) ? OUT_W'(1) : '0;
    end else begin
      wr_data = ws_new;
    end
  end

  // ping-pong row stores, one write and two registered reads each
  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      mem0_q[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      mem1_q[wr_addr] <= wr_data;
    end
    rd0a_q <= mem0_q[addr_a];
    rd0b_q <= mem0_q[addr_b];
    rd1a_q <= mem1_q[addr_a];
    rd1b_q <= mem1_q[addr_b];
  end

  // window sum update: ws + prev[j] - prev[j-i], mod prime
  assign prev_a = stg_bank_q ? rd0a_q : rd1a_q;
  assign prev_b = stg_sub_q ? (stg_bank_q ? rd0b_q : rd1b_q) : '0;
  assign base   = stg_first_q ? '0 : ws_q;
  assign t_sum  = $signed({2'b00, base}) + $signed({2'b00, prev_a})
                - $signed({2'b00, prev_b});

  always_comb begin
    priority if (t_sum < 0) begin
      ws_new = OUT_W'(t_sum + PRIME_S);
    end else if (t_sum >= PRIME_S) begin
      ws_new = OUT_W'(t_sum - PRIME_S);
    end else begin
      ws_new = OUT_W'(t_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
    end else if (stg_vld_q) begin
      ws_q <= ws_new;
    end
  end

  // result register, final row sits in the bank of n's parity
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      perm_q <= n_q[0] ? rd1a_q : rd0a_q;
    end
  end

  assign perm_count_o    = perm_q;
  assign stat_o.col_last = j_last;
  assign stat_o.row_last = (i_q == n_q);
  assign stat_o.n_zero   = (n_q == '0);

  `KIP_ASSERT_NOW(a_sum_reduced, stg_vld_q, ws_new < PRIME,
                  "window sum left the residue range")
  `KIP_ASSERT_NOW(a_col_in_range, cmd_i.row_step || cmd_i.init_step, j_q <= k_q,
                  "column counter ran past k")
  `KIP_ASSERT_NOW(a_bank_matches_row, stg_vld_q, stg_bank_q == i_q[0],
                  "write back bank does not match the current row")

endmodule

FILE: hw/rtl/k_inversion_permutation_count_unit.sv
// ----------------------------------------------------------------------------
// k_inversion_permutation_count_unit
// Permutations of n elements with exactly k inversions, modulo 1000000007
// ----------------------------------------------------------------------------
// Usage: a request beat on in_i carries elem_count (n) and inversions (k);
// values above MAX_N / MAX_K saturate to the bounds. Each request yields one
// beat on out_o carrying perm_count.
// Sequence: with n and k after saturation, row zero is filled first, then
// each of the n rows takes k+1 column updates plus a write-back step, and
// the final entry is read. The running-sum loop writes one row-store entry
// per cycle.
// Throughput: one request at a time; in_i.ready is high only while idle, and
// the sequencer returns to idle as the result is registered.
// Stall: the result sits in an output register; a new request is accepted
// and worked on while it waits, and the block holds its next result until
// out_o.ready frees the register.
// Reset: rst_ni clears the sequencer, counters and output valid; the row
// stores need no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module k_inversion_permutation_count_unit import kip_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF,
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kip_in_if.sink    in_i,
  kip_out_if.source out_o
);

  kip_cmd_t  cmd;
  kip_stat_t stat;

  // sequencer
  kip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // row stores and arithmetic
  kip_dpath #(
    .MAX_N (MAX_N),
    .MAX_K (MAX_K)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .elem_count_i (in_i.elem_count),
    .inversions_i (in_i.inversions),
    .perm_count_o (out_o.perm_count)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inversion count unit: a table of directed (n, k)
// requests, then random requests, each result beat compared against its typed-in
// count or a row-by-row Mahonian count predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import kip_pkg::*;

  // run shape
  localparam int          N_DIRECTED   = 23;
  localparam int          N_RANDOM     = 77;
  localparam int          IDLE_PCT     = 18;
  localparam int          HOLD_AT      = N_DIRECTED + 15;
  localparam int          HOLD_CYCLES  = 12000;
  localparam int          DRAIN_CYCLES = 32;
  localparam int          MAX_REPORTS  = 20;
  localparam int unsigned CYCLE_LIMIT  = 8000000;

  // one directed request, with its count typed in where it is obvious
  typedef struct {
    logic [IN_W-1:0]  n;
    logic [IN_W-1:0]  k;
    bit               known;
    logic [OUT_W-1:0] cnt;
  } req_row_t;

  req_row_t directed_tbl [N_DIRECTED] = '{
    '{11'd0,    11'd0,    1'b1, 30'd1},     // empty set, no inversions
    '{11'd0,    11'd1,    1'b1, 30'd0},     // empty set, some inversions
    '{11'd0,    11'd2047, 1'b1, 30'd0},     // empty set, k saturates
    '{11'd1,    11'd0,    1'b1, 30'd1},
    '{11'd1,    11'd1,    1'b1, 30'd0},
    '{11'd1,    11'd2047, 1'b1, 30'd0},
    '{11'd7,    11'd0,    1'b1, 30'd1},     // k zero
    '{11'd1024, 11'd0,    1'b1, 30'd1},     // n at bound, k zero
    '{11'd2047, 11'd0,    1'b1, 30'd1},     // n saturates, k zero
    '{11'd2047, 11'd1,    1'b1, 30'd1023},  // single inversion: n-1 ways
    '{11'd2,    11'd1,    1'b1, 30'd1},
    '{11'd3,    11'd1,    1'b0, 30'd0},
    '{11'd3,    11'd3,    1'b0, 30'd0},
    '{11'd4,    11'd3,    1'b0, 30'd0},
    '{11'd4,    11'd6,    1'b0, 30'd0},     // fully reversed
    '{11'd4,    11'd7,    1'b0, 30'd0},     // past the most inversions
    '{11'd12,   11'd66,   1'b0, 30'd0},
    '{11'd12,   11'd67,   1'b0, 30'd0},
    '{11'd10,   11'd20,   1'b0, 30'd0},
    '{11'd3,    11'd2047, 1'b0, 30'd0},     // k saturates
    '{11'd5,    11'd1025, 1'b0, 30'd0},     // k just above bound
    '{11'd1025, 11'd3,    1'b0, 30'd0},     // n just above bound
    '{11'd2047, 11'd2047, 1'b0, 30'd0}      // both saturate: the full table
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  kip_in_if  req_if ();
  kip_out_if res_if ();

  k_inversion_permutation_count_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // counts still owed by the block, oldest first
  logic [OUT_W-1:0] pending_counts [$];
  int unsigned      err_count;
  int unsigned      counts_seen;
  int unsigned      cycle_count;

  // predictor row stores
  logic [OUT_W-1:0] base_row [0:MAX_K_DEF];
  logic [OUT_W-1:0] next_row [0:MAX_K_DEF];

  // permutations of n with exactly k inversions, mod the prime
  function automatic logic [OUT_W-1:0] mahonian_count(input logic [IN_W-1:0] n_raw,
                                                      input logic [IN_W-1:0] k_raw);
    int unsigned  n;
    int unsigned  k;
    int unsigned  i;
    int unsigned  j;
    logic [OUT_W:0] win;
    n = (32'(n_raw) > MAX_N_DEF) ? MAX_N_DEF : 32'(n_raw);
    k = (32'(k_raw) > MAX_K_DEF) ? MAX_K_DEF : 32'(k_raw);
    // row zero: one way to arrange nothing
    for (j = 0; j <= k; j++) base_row[j] = (j == 0) ? 30'd1 : 30'd0;
    // each row is a sliding window of width i over the row above
    for (i = 1; i <= n; i++) begin
      win = '0;
      for (j = 0; j <= k; j++) begin
        win = win + base_row[j];
        if (win >= PRIME) win = win - PRIME;
        if (j >= i) begin
          win = win + (PRIME - base_row[j-i]);
          if (win >= PRIME) win = win - PRIME;
        end
        next_row[j] = win[OUT_W-1:0];
      end
      for (j = 0; j <= k; j++) base_row[j] = next_row[j];
    end
    return base_row[k];
  endfunction

  // one line per mismatch, capped, always counted
  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // offer one request beat and hold it until the block takes it
  task automatic offer_pair(input logic [IN_W-1:0] n, input logic [IN_W-1:0] k,
                            input bit quiet);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.elem_count <= n;
    req_if.inversions <= k;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // reset and request side
  initial begin : req_side
    int               idx;
    int               sel;
    int unsigned      tri_max;
    logic [IN_W-1:0]  n;
    logic [IN_W-1:0]  k;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.elem_count = '0;
    req_if.inversions = '0;
    err_count         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (idx = 0; idx < N_DIRECTED; idx++) begin
      offer_pair(directed_tbl[idx].n, directed_tbl[idx].k, 1'b0);
      if (directed_tbl[idx].known) pending_counts.push_back(directed_tbl[idx].cnt);
      else pending_counts.push_back(mahonian_count(directed_tbl[idx].n, directed_tbl[idx].k));
    end

    // random requests, mostly small tables
    for (idx = 0; idx < N_RANDOM; idx++) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        // any n, including saturated, with a narrow row
        n = IN_W'($urandom_range(2047));
        k = IN_W'($urandom_range(8));
      end else if (sel < 20) begin
        // any k, including saturated, with few rows
        n = IN_W'($urandom_range(4));
        k = IN_W'($urandom_range(2047));
      end else if (sel < 35) begin
        // around the most inversions n can have
        n       = IN_W'($urandom_range(1, 12));
        tri_max = 32'(n) * (32'(n) - 1) / 2;
        k       = (tri_max == 0) ? IN_W'($urandom_range(1))
                                 : IN_W'(tri_max - 1 + $urandom_range(2));
      end else begin
        n = IN_W'($urandom_range(40));
        k = IN_W'($urandom_range(40));
      end
      offer_pair(n, k, (idx >= 50 && idx < 70));
      pending_counts.push_back(mahonian_count(n, k));
    end
    req_if.valid <= 1'b0;

    // wait for the last count, then make sure nothing else shows up
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: check each beat, then pick next ready
  initial begin : res_side
    int unsigned      hold_left;
    bit               held;
    logic [OUT_W-1:0] want;
    hold_left    = 0;
    held         = 1'b0;
    counts_seen  = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        counts_seen++;
        if (pending_counts.size() == 0) begin
          note_mismatch($sformatf("unexpected count %0d", res_if.perm_count));
        end else begin
          want = pending_counts.pop_front();
          if (res_if.perm_count !== want)
            note_mismatch($sformatf("perm_count %0d, want %0d", res_if.perm_count, want));
        end
      end
      // one long hold-off so the block fills up and stalls its input
      if (!held && counts_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (counts_seen >= N_DIRECTED + 60 && counts_seen < N_DIRECTED + 80) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
